// ===== src/zone_median_cold_reject_assert.svh =====
// assertion macros shared by the checker
`ifndef ZONE_MEDIAN_COLD_REJECT_ASSERT_SVH
`define ZONE_MEDIAN_COLD_REJECT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ZMCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ZMCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/zmcr_pkg.sv =====
package zmcr_pkg;

    localparam int ZONE_PIXELS_DEF = 8;
    localparam int PIX_W           = 16;
    localparam int ZONE_W          = 3;
    localparam int COUNT_W         = 4;
    localparam int MARGIN_W        = 15;
    localparam int LIMIT_W         = 18;
    localparam int OUT_TDATA_W     = 24;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 15'd640;

    typedef logic signed [PIX_W-1:0]   pixel_t;
    typedef logic signed [LIMIT_W-1:0] limit_t;
    typedef logic [ZONE_W-1:0]         zone_t;
    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic [MARGIN_W-1:0]       margin_t;

    // one load strobe per pipeline stage
    typedef struct packed {
        logic rank;
        logic sort;
        logic limit;
        logic trim;
        logic out;
    } stage_load_t;

    // floor of the mean of two values
    function automatic pixel_t half_sum(input pixel_t a, input pixel_t b);
        logic signed [PIX_W:0] s;
        s = {a[PIX_W-1], a} + {b[PIX_W-1], b};
        return s[PIX_W:1];
    endfunction

endpackage

// ===== src/zmcr_rank_lane.sv =====
module zmcr_rank_lane
    import zmcr_pkg::*;
#(
    parameter int ZONE_PIXELS = ZONE_PIXELS_DEF,
    parameter int LANE        = 0,
    localparam int RW         = $clog2(ZONE_PIXELS)
)
(
    input  pixel_t          pix [ZONE_PIXELS],
    output logic [RW-1:0]   rank
);

    logic [ZONE_PIXELS-1:0] ahead;

    // ties broken by lane order so every rank is unique
    always_comb
    begin
        for (int j = 0; j < ZONE_PIXELS; j++)
        begin
            if (j < LANE)
            begin
                ahead[j] = (pix[j] <= pix[LANE]);
            end
            else if (j > LANE)
            begin
                ahead[j] = (pix[j] < pix[LANE]);
            end
            else
            begin
                ahead[j] = 1'b0;
            end
        end
        rank = RW'($countones(ahead));
    end

endmodule

// ===== src/zmcr_sort_median.sv =====
module zmcr_sort_median
    import zmcr_pkg::*;
#(
    parameter int ZONE_PIXELS = ZONE_PIXELS_DEF,
    localparam int RW         = $clog2(ZONE_PIXELS)
)
(
    input  logic          clk,
    input  stage_load_t   ld,
    input  pixel_t        val [ZONE_PIXELS],
    input  logic [RW-1:0] rank [ZONE_PIXELS],
    input  margin_t       margin,
    output pixel_t        sorted [ZONE_PIXELS],
    output limit_t        limit
);

    localparam int MID = ZONE_PIXELS / 2;

    pixel_t sorted_d  [ZONE_PIXELS];
    pixel_t sorted1_reg [ZONE_PIXELS];
    pixel_t sorted2_reg [ZONE_PIXELS];
    limit_t limit_reg;
    pixel_t med0;
    limit_t limit_next;

    // scatter each lane's value to its rank
    always_comb
    begin
        for (int k = 0; k < ZONE_PIXELS; k++)
        begin
            sorted_d[k] = '0;
            for (int i = 0; i < ZONE_PIXELS; i++)
            begin
                if (rank[i] == RW'(k))
                begin
                    sorted_d[k] = sorted_d[k] | val[i];
                end
            end
        end
    end

    always_comb
    begin
        if ((ZONE_PIXELS % 2) != 0)
        begin
            med0 = sorted1_reg[MID];
        end
        else
        begin
            med0 = half_sum(sorted1_reg[MID-1], sorted1_reg[MID]);
        end
        limit_next = {{(LIMIT_W-PIX_W){med0[PIX_W-1]}}, med0}
                   - {{(LIMIT_W-MARGIN_W){1'b0}}, margin};
    end

    always_ff @(posedge clk)
    begin
        if (ld.sort)
        begin
            sorted1_reg <= sorted_d;
        end
        if (ld.limit)
        begin
            sorted2_reg <= sorted1_reg;
            limit_reg   <= limit_next;
        end
    end

    assign sorted = sorted2_reg;
    assign limit  = limit_reg;

endmodule

// ===== src/zmcr_trim.sv =====
module zmcr_trim
    import zmcr_pkg::*;
#(
    parameter int ZONE_PIXELS = ZONE_PIXELS_DEF,
    localparam int IW         = $clog2(ZONE_PIXELS),
    localparam int CW         = $clog2(ZONE_PIXELS + 1)
)
(
    input  logic        clk,
    input  stage_load_t ld,
    input  pixel_t      sorted [ZONE_PIXELS],
    input  limit_t      limit,
    output pixel_t      median,
    output count_t      kept_count
);

    logic [ZONE_PIXELS-1:0] below;
    logic [CW-1:0]          first;
    logic [CW-1:0]          kept;
    logic [CW-1:0]          idx_wide;

    pixel_t        sorted3_reg [ZONE_PIXELS];
    logic [IW-1:0] idx_reg;
    logic          odd_reg;
    count_t        kept_reg;

    logic [IW-1:0] idx_lo;
    pixel_t        hi_val;
    pixel_t        lo_val;

    // sorted order makes the rejected values a prefix
    always_comb
    begin
        for (int k = 0; k < ZONE_PIXELS; k++)
        begin
            below[k] = ($signed({{(LIMIT_W-PIX_W){sorted[k][PIX_W-1]}}, sorted[k]}) < limit);
        end
        first    = CW'($countones(below));
        kept     = CW'(ZONE_PIXELS) - first;
        idx_wide = first + (kept >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (ld.trim)
        begin
            sorted3_reg <= sorted;
            idx_reg     <= idx_wide[IW-1:0];
            odd_reg     <= kept[0];
            kept_reg    <= COUNT_W'(kept);
        end
    end

    always_comb
    begin
        idx_lo = (idx_reg == '0) ? '0 : idx_reg - IW'(1);
        hi_val = sorted3_reg[idx_reg];
        lo_val = sorted3_reg[idx_lo];
        median = odd_reg ? hi_val : half_sum(lo_val, hi_val);
    end

    assign kept_count = kept_reg;

endmodule

// ===== src/zone_median_cold_reject.sv =====
// channel   dir  tdata fields (lsb first)                          other
// s_axis    in   zone_index[3], pixel_0..pixel_N-1[16 each], pad   tvalid, tready
// m_axis    out  zone_number[3], zone_median[16], kept_count[4]    tvalid, tready
// cfg       in   cold_margin[15]                                   cfg_we
//
// five register stages: rank lanes, scatter, limit, trim, output
// one item per cycle sustained while the output is not stalled
// each stage holds while the next cannot accept, so bubbles close up under back-pressure
// rst_n clears stage valids and sets cold_margin to 640
module zone_median_cold_reject
    import zmcr_pkg::*;
#(
    parameter int ZONE_PIXELS = ZONE_PIXELS_DEF,
    localparam int RW         = $clog2(ZONE_PIXELS),
    localparam int IN_TDATA_W = ((ZONE_W + PIX_W * ZONE_PIXELS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // zone_index, pixel_0 .. pixel_n-1, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // zone_number, zone_median, kept_count, zero pad
    input  logic                  cfg_we,
    input  margin_t               cfg_wdata
);

    localparam int NST = 5;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] rdy;
    logic [NST-1:0] load;
    stage_load_t    ld;

    margin_t        margin_reg;
    zone_t          zone_reg [NST];

    pixel_t         pix_in  [ZONE_PIXELS];
    logic [RW-1:0]  rank_in [ZONE_PIXELS];
    pixel_t         val0_reg  [ZONE_PIXELS];
    logic [RW-1:0]  rank0_reg [ZONE_PIXELS];

    pixel_t         sorted2 [ZONE_PIXELS];
    limit_t         limit2;
    pixel_t         median3;
    count_t         kept3;
    pixel_t         median_reg;
    count_t         kept_reg;

    always_comb
    begin
        for (int i = 0; i < ZONE_PIXELS; i++)
        begin
            pix_in[i] = s_tdata[ZONE_W + PIX_W * i +: PIX_W];
        end
    end

    generate
        for (genvar g = 0; g < ZONE_PIXELS; g++)
        begin : g_lane
            zmcr_rank_lane #(
                .ZONE_PIXELS (ZONE_PIXELS),
                .LANE        (g)
            ) u_lane (
                .pix  (pix_in),
                .rank (rank_in[g])
            );
        end
    endgenerate

    // per-stage handshake
    always_comb
    begin
        rdy[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        load[0] = s_tvalid && rdy[0];
        for (int k = 1; k < NST; k++)
        begin
            load[k] = valid_reg[k-1] && rdy[k];
        end
        for (int k = 0; k < NST - 1; k++)
        begin
            valid_next[k] = load[k] || (valid_reg[k] && !rdy[k+1]);
        end
        valid_next[NST-1] = load[NST-1] || (valid_reg[NST-1] && !m_tready);
    end

    assign ld.rank  = load[0];
    assign ld.sort  = load[1];
    assign ld.limit = load[2];
    assign ld.trim  = load[3];
    assign ld.out   = load[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            margin_reg <= MARGIN_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                margin_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.rank)
        begin
            val0_reg    <= pix_in;
            rank0_reg   <= rank_in;
            zone_reg[0] <= s_tdata[ZONE_W-1:0];
        end
        for (int k = 1; k < NST; k++)
        begin
            if (load[k])
            begin
                zone_reg[k] <= zone_reg[k-1];
            end
        end
        if (ld.out)
        begin
            median_reg <= median3;
            kept_reg   <= kept3;
        end
    end

    zmcr_sort_median #(
        .ZONE_PIXELS (ZONE_PIXELS)
    ) u_sort (
        .clk    (clk),
        .ld     (ld),
        .val    (val0_reg),
        .rank   (rank0_reg),
        .margin (margin_reg),
        .sorted (sorted2),
        .limit  (limit2)
    );

    zmcr_trim #(
        .ZONE_PIXELS (ZONE_PIXELS)
    ) u_trim (
        .clk        (clk),
        .ld         (ld),
        .sorted     (sorted2),
        .limit      (limit2),
        .median     (median3),
        .kept_count (kept3)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = {{(OUT_TDATA_W - ZONE_W - PIX_W - COUNT_W){1'b0}},
                       kept_reg, median_reg, zone_reg[NST-1]};

endmodule

// ===== src/zmcr_checker.sv =====
module zmcr_checker
    import zmcr_pkg::*;
#(
    parameter int ZONE_PIXELS = ZONE_PIXELS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

`include "zone_median_cold_reject_assert.svh"

    localparam int KLO = ZONE_W + PIX_W;
    localparam int KMIN = ZONE_PIXELS / 2;

    logic   count_ok;
    count_t kept;

    assign kept     = m_tdata[KLO +: COUNT_W];
    assign count_ok = (ZONE_PIXELS >= 16)
                   || ((int'(kept) >= KMIN) && (int'(kept) <= ZONE_PIXELS));

    `ZMCR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
    `ZMCR_ASSERT_NOW(a_ready_only_on_backpressure, !s_tready, m_tvalid && !m_tready, "input stalled without output back-pressure")
    `ZMCR_ASSERT_NOW(a_kept_range, m_tvalid, count_ok, "kept count outside upper-half bound")
    `ZMCR_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1] == 1'b0, "output pad bit set")

endmodule

bind zone_median_cold_reject zmcr_checker #(
    .ZONE_PIXELS (ZONE_PIXELS)
) u_zmcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
